// ===== src/plc_pkg.sv =====
// Package for the positional list store: operation and status codes,
// field widths and the command that the top level broadcasts to every cell.
// No dependencies.
package plc_pkg;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Width that holds both a position and a length, plus one bit of headroom
  function automatic int cmp_w(input int len_w);
    cmp_w = ((len_w > POS_W) ? len_w : POS_W) + 1;
  endfunction

  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } cell_cmd_t;

endpackage

// ===== src/positional_list_store.sv =====
// Top level of the positional list store: control, output register and
// the chain of plc_cell instances. Depends on plc_pkg and plc_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per
//   transaction: opcode (insert, read, delete), position and value.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   input transaction: read_value, status and entry_count after the op.
//   The result is registered: it appears in the cycle after the transaction.
//   Throughput: one operation per cycle unless stalled. Every cell compares
//   its own index against the broadcast command and loads its new entry in
//   that same cycle, so inserts and deletes shift the whole list at once.
//   Stall: while a result sits unaccepted with out_stall high, in_stall is
//   raised and the held result stays stable; the store does not change.
//   Reset (rst, synchronous): empty the list and drop any pending result.
//   Entry contents are not cleared; positions at or above the length are
//   never read, and an insert beyond the end writes zeros into the gap.
//   Opcode 3 is a no-op that still returns a result with status done.
module positional_list_store #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [plc_pkg::OP_W-1:0]          opcode,
  input  logic [plc_pkg::POS_W-1:0]         position,
  input  logic signed [plc_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [plc_pkg::DATA_W-1:0] read_value,
  output logic [plc_pkg::STATUS_W-1:0]      status,
  output logic [plc_pkg::COUNT_W-1:0]       entry_count
);
  import plc_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = cmp_w(LEN_W);
  localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         len_next;
  logic [CMP_W-1:0]         len_x;
  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         base;
  logic                     accept;
  logic                     full;
  logic                     absent;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] rd_next;
  logic [STATUS_W-1:0]      st_next;
  cell_cmd_t                cmd;

  // Hold new inputs while a finished result waits downstream
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign len_x  = CMP_W'(len);
  assign pos_x  = CMP_W'(position);
  assign base   = (pos_x > len_x) ? pos_x : len_x;   // length after padding
  assign full   = (base >= CMP_W'(CAPACITY));
  assign absent = (pos_x >= len_x);

  // Broadcast the command; only a legal insert or delete moves the cells
  always_comb begin
    cmd.ins_en = accept && (opcode == OP_INSERT) && !full;
    cmd.del_en = accept && (opcode == OP_DELETE) && !absent;
    cmd.pos    = position;
    cmd.val    = value;
  end

  // Read port over the positions that a position field can address
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_x == CMP_W'(i)) begin
        rd_data = cell_data[i];
      end
    end
  end

  always_comb begin
    len_next = len;
    rd_next  = '0;
    st_next  = ST_DONE;
    case (opcode)
      OP_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          len_next = LEN_W'(base + CMP_W'(1));
        end
      end
      OP_READ: begin
        if (absent) begin
          st_next = ST_ABSENT;
        end else begin
          rd_next = rd_data;
        end
      end
      OP_DELETE: begin
        if (absent) begin
          st_next = ST_ABSENT;
        end else begin
          len_next = len - LEN_W'(1);
        end
      end
      default: begin
        len_next = len;
      end
    endcase
  end

  // Chain of cells; each cell sees its two neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    plc_cell #(
      .IDX   (g),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .len   (len_x),
      .base  (base),
      .lower (lower),
      .upper (upper),
      .data  (cell_data[g])
    );
  end

  // Length and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        len       <= len_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value  <= rd_next;
      status      <= st_next;
      entry_count <= COUNT_W'(len_next);
    end
  end

endmodule

// ===== src/plc_cell.sv =====
// One storage cell of the list chain: holds the entry at position IDX.
// Depends on plc_pkg; takes its neighbors' entries on insert and delete.
module plc_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 6
) (
  input  logic                              clk,
  input  plc_pkg::cell_cmd_t                cmd,
  input  logic [CMP_W-1:0]                  len,
  input  logic [CMP_W-1:0]                  base,
  input  logic signed [plc_pkg::DATA_W-1:0] lower,
  input  logic signed [plc_pkg::DATA_W-1:0] upper,
  output logic signed [plc_pkg::DATA_W-1:0] data
);
  import plc_pkg::*;

  localparam logic [CMP_W-1:0] ME  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] ME1 = CMP_W'(IDX + 1);

  logic [CMP_W-1:0]         pos_x;
  logic signed [DATA_W-1:0] data_next;

  assign pos_x = CMP_W'(cmd.pos);

  always_comb begin
    data_next = data;
    if (cmd.ins_en) begin
      if (ME == pos_x) begin
        data_next = cmd.val;
      end else if (ME < pos_x && ME >= len) begin
        data_next = '0;                         // pad the gap
      end else if (ME > pos_x && ME <= base) begin
        data_next = lower;                      // shift up
      end
    end else if (cmd.del_en) begin
      if (ME >= pos_x && ME1 < len) begin
        data_next = upper;                      // shift down
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== src/plc_checker.sv =====
// Port-level checks for positional_list_store, bound to the top level.
// Depends on plc_pkg for the status codes.
module plc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [plc_pkg::DATA_W-1:0] read_value,
  input logic [plc_pkg::STATUS_W-1:0]      status,
  input logic [plc_pkg::COUNT_W-1:0]       entry_count
);
  import plc_pkg::*;

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Every accepted transaction yields a result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result one cycle after accepted transaction");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(read_value) && $stable(status) && $stable(entry_count)))
    else $error("stalled result changed");

  // Failed operations return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DONE) |-> (read_value == '0))
    else $error("nonzero read_value on failed operation");

endmodule

bind positional_list_store plc_checker u_plc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_value  (read_value),
  .status      (status),
  .entry_count (entry_count)
);
